FILE: src/srbo_pkg.sv
// Package for the sample ring buffer with overwrite.
// Holds request and status codes, the controller state type and the
// command/status structs shared by the controller and the datapath.
package srbo_pkg;

  // Request codes carried in the input tuser
  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_PEEK  = 3'd2;
  localparam logic [2:0] REQ_SKIP  = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ERROR    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 7;
  localparam int SKIP_W   = 10;
  localparam int SIZE_W   = 11;
  localparam int STORED_W = 10;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_EXEC,
    ST_RESULT,
    ST_READ,
    ST_WAIT
  } ctrl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic cfg_write;
    logic capture;
    logic calc;
    logic exec;
    logic load_single;
    logic rd_issue;
    logic load_sample;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic burst;
    logic remain_zero;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/srbo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srbo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/srbo_ctrl.sv
// Controller state machine for the sample ring buffer.
// Depends on srbo_pkg; drives the datapath through ctrl_cmd_t commands.
module srbo_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  srbo_pkg::dp_stat_t stat,
  output srbo_pkg::ctrl_cmd_t cmd
);

  srbo_pkg::ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srbo_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      srbo_pkg::ST_IDLE: begin
        if (s_tvalid && !cfg_valid) state_next = srbo_pkg::ST_CALC;
      end
      srbo_pkg::ST_CALC: state_next = srbo_pkg::ST_EXEC;
      srbo_pkg::ST_EXEC: begin
        state_next = stat.burst ? srbo_pkg::ST_READ : srbo_pkg::ST_RESULT;
      end
      srbo_pkg::ST_RESULT: begin
        if (stat.out_free) state_next = srbo_pkg::ST_IDLE;
      end
      srbo_pkg::ST_READ: state_next = srbo_pkg::ST_WAIT;
      srbo_pkg::ST_WAIT: begin
        if (stat.out_free) begin
          state_next = stat.remain_zero ? srbo_pkg::ST_IDLE : srbo_pkg::ST_READ;
        end
      end
      default: state_next = srbo_pkg::ST_IDLE;
    endcase
  end

  // Output logic; a configuration write takes precedence over a request when idle
  always_comb begin
    cmd       = '0;
    s_tready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state)
      srbo_pkg::ST_IDLE: begin
        cfg_ready     = 1'b1;
        s_tready      = !cfg_valid;
        cmd.cfg_write = cfg_valid;
        cmd.capture   = s_tvalid && !cfg_valid;
      end
      srbo_pkg::ST_CALC:   cmd.calc = 1'b1;
      srbo_pkg::ST_EXEC:   cmd.exec = 1'b1;
      srbo_pkg::ST_RESULT: cmd.load_single = stat.out_free;
      srbo_pkg::ST_READ:   cmd.rd_issue = 1'b1;
      srbo_pkg::ST_WAIT:   cmd.load_sample = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: src/srbo_dp.sv
// Datapath of the sample ring buffer: pointers, occupancy, sample RAM
// and the output register. Depends on srbo_pkg and srbo_ram.
module srbo_dp #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [srbo_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [2:0]                          s_tuser,
  input  logic [srbo_pkg::SIZE_W-1:0]         cfg_data,
  input  srbo_pkg::ctrl_cmd_t                 cmd,
  output srbo_pkg::dp_stat_t                  stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [srbo_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW + 1 > srbo_pkg::SIZE_W) ? AW + 1 : srbo_pkg::SIZE_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] MIN_SLOTS = CW'(2);
  localparam logic [CW-1:0] RESET_SLOTS = (DEPTH < 1024) ? DEPTH_C : CW'(1024);

  // Advance an index by n, wrapping once at the slot count
  function automatic logic [CW-1:0] adv(input logic [CW-1:0] idx,
                                        input logic [CW-1:0] n,
                                        input logic [CW-1:0] slots);
    logic [CW-1:0] sum;
    sum = idx + n;
    if (sum >= slots) sum = sum - slots;
    return sum;
  endfunction

  // Captured request
  logic [2:0]                      req_r;
  logic [srbo_pkg::SAMPLE_W-1:0]   din_r;
  logic [srbo_pkg::COUNT_W-1:0]    cnt_r;
  logic [srbo_pkg::SKIP_W-1:0]     skip_r;

  // Buffer state
  logic [CW-1:0] slots_r;
  logic [AW-1:0] head_r, tail_r;
  logic [CW-1:0] stored_r;
  logic [CW-1:0] after_r;
  logic [1:0]    status_r;
  logic [AW-1:0] pos_r;
  logic [srbo_pkg::COUNT_W-1:0] remain_r;

  // Output register
  logic                          out_valid;
  logic [srbo_pkg::SAMPLE_W-1:0] out_data;
  logic                          out_flag;
  logic                          out_last;
  logic [1:0]                    out_status;
  logic [srbo_pkg::STORED_W-1:0] out_stored;

  // RAM signals
  logic [srbo_pkg::SAMPLE_W-1:0] ram_rdata;
  logic                          ram_we;

  // Execute-step results
  logic [CW-1:0] head_ext, tail_ext, cnt_ext, skip_ext;
  logic [CW-1:0] head_next, tail_next, after_next;
  logic [1:0]    status_next;
  logic          burst;
  logic          cnt_err, drop_ovf;
  logic [CW-1:0] drop_head, drop_after;
  logic [CW-1:0] size_ext, slots_next, pos_adv;

  assign head_ext = CW'(head_r);
  assign tail_ext = CW'(tail_r);
  assign cnt_ext  = CW'(cnt_r);
  assign skip_ext = CW'(skip_r);

  // Slot count from the size register, clamped to the supported range
  always_comb begin
    size_ext = CW'(cfg_data);
    if (size_ext < MIN_SLOTS) slots_next = MIN_SLOTS;
    else if (size_ext > DEPTH_C) slots_next = DEPTH_C;
    else slots_next = size_ext;
  end

  // Drop of skip_count samples from the head
  assign drop_ovf   = skip_ext > stored_r;
  assign drop_head  = drop_ovf ? tail_ext : adv(head_ext, skip_ext, slots_r);
  assign drop_after = drop_ovf ? '0 : stored_r - skip_ext;
  assign cnt_err    = (cnt_r > srbo_pkg::COUNT_W'(MAX_BURST)) || (cnt_ext > stored_r);

  // Request decision and pointer update
  always_comb begin
    head_next   = head_ext;
    tail_next   = tail_ext;
    after_next  = stored_r;
    status_next = srbo_pkg::ST_OK;
    burst       = 1'b0;
    ram_we      = 1'b0;
    unique case (req_r)
      srbo_pkg::REQ_WRITE: begin
        ram_we    = cmd.exec;
        tail_next = adv(tail_ext, CW'(1), slots_r);
        if (stored_r == slots_r - CW'(1)) begin
          head_next   = adv(head_ext, CW'(1), slots_r);
          status_next = srbo_pkg::ST_OVERFLOW;
        end else begin
          after_next = stored_r + CW'(1);
        end
      end
      srbo_pkg::REQ_READ: begin
        if (cnt_err) begin
          status_next = srbo_pkg::ST_ERROR;
        end else begin
          burst      = cnt_r != '0;
          head_next  = adv(head_ext, cnt_ext, slots_r);
          after_next = stored_r - cnt_ext;
        end
      end
      srbo_pkg::REQ_PEEK: begin
        if (cnt_err) begin
          status_next = srbo_pkg::ST_ERROR;
        end else begin
          burst       = cnt_r != '0;
          head_next   = drop_head;
          after_next  = drop_after;
          status_next = drop_ovf ? srbo_pkg::ST_OVERFLOW : srbo_pkg::ST_OK;
        end
      end
      srbo_pkg::REQ_SKIP: begin
        head_next   = drop_head;
        after_next  = drop_after;
        status_next = drop_ovf ? srbo_pkg::ST_OVERFLOW : srbo_pkg::ST_OK;
      end
      srbo_pkg::REQ_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        after_next = '0;
      end
      default: begin
        head_next = head_ext;
      end
    endcase
  end

  assign pos_adv = adv(CW'(pos_r), CW'(1), slots_r);

  // Request capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= s_tuser;
      din_r  <= s_tdata[15:0];
      cnt_r  <= s_tdata[22:16];
      skip_r <= s_tdata[32:23];
    end
    if (cmd.calc) begin
      stored_r <= (tail_r >= head_r) ? tail_ext - head_ext : slots_r - head_ext + tail_ext;
    end
    if (cmd.exec) begin
      after_r  <= after_next;
      status_r <= status_next;
      pos_r    <= head_r;
      remain_r <= cnt_r;
    end
    if (cmd.rd_issue) begin
      pos_r    <= pos_adv[AW-1:0];
      remain_r <= remain_r - srbo_pkg::COUNT_W'(1);
    end
  end

  // Pointers and slot count
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_r <= RESET_SLOTS;
      head_r  <= '0;
      tail_r  <= '0;
    end else if (cmd.cfg_write) begin
      slots_r <= slots_next;
      head_r  <= '0;
      tail_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_next[AW-1:0];
      tail_r <= tail_next[AW-1:0];
    end
  end

  // Sample store
  srbo_ram #(
    .WIDTH (srbo_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (din_r),
    .re    (cmd.rd_issue),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  // Output register; a new result loads when the old one is gone or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_sample) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      out_data   <= '0;
      out_flag   <= 1'b0;
      out_last   <= 1'b1;
      out_status <= status_r;
      out_stored <= after_r[srbo_pkg::STORED_W-1:0];
    end else if (cmd.load_sample) begin
      out_data   <= ram_rdata;
      out_flag   <= 1'b1;
      out_last   <= remain_r == '0;
      out_status <= status_r;
      out_stored <= after_r[srbo_pkg::STORED_W-1:0];
    end
  end

  assign stat.burst       = burst;
  assign stat.remain_zero = remain_r == '0;
  assign stat.out_free    = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_stored, out_status, out_data};
  assign m_tuser  = out_flag;
  assign m_tlast  = out_last;

endmodule

FILE: src/sample_ring_buffer_overwrite_top.sv
// Top level of the sample ring buffer with overwrite.
// Depends on srbo_pkg, srbo_ctrl, srbo_dp and srbo_ram.
//
//   Channel   Direction  Handshake            Payload
//   s_*       in         s_tvalid/s_tready    tdata: data_in, count, skip_count; tuser: req_type
//   m_*       out        m_tvalid/m_tready    tdata: data_out, status, stored_count;
//                                             tuser: data_valid; tlast: last
//   cfg_*     in         cfg_valid/cfg_ready  cfg_data: buffer_size
//
// A request without samples goes through the calc, execute and result states before its result loads.
// In a read or peek of n samples, each sample is one registered RAM read followed by a load
// of the output register. One request is worked on at a time.
// Reset empties the buffer and sets the size to 1024 slots; the sample RAM is not cleared.
// A full output register holds the controller until the result is taken; the next request
// is accepted while the final result of the previous one still waits.
module sample_ring_buffer_overwrite_top #(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] data_in, [22:16] count, [32:23] skip_count, zero pad
  input  logic [2:0]  s_tuser,   // [2:0] req_type
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] data_out, [17:16] status, [27:18] stored_count, pad
  output logic        m_tuser,   // [0] data_valid
  output logic        m_tlast,
  // Size register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  srbo_pkg::ctrl_cmd_t cmd;
  srbo_pkg::dp_stat_t  stat;

  // Sequencer
  srbo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Pointers, storage and output register
  srbo_dp #(
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: bench/sample_ring_buffer_overwrite_top_test.sv
// Self-checking testbench for the sample ring buffer with overwrite.
// Depends on srbo_pkg and sample_ring_buffer_overwrite_top; a scoreboard class
// tracks the buffer contents and compares every result against its own prediction.
module sample_ring_buffer_overwrite_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BATCH = 26;
  localparam int SETTLE       = 8;
  localparam int TAIL_WAIT    = 24;
  localparam int PLAN_LEN     = 8;
  // Sizes visited by the random part: both clamps, the smallest and largest real sizes.
  localparam logic [10:0] SIZE_PLAN [0:PLAN_LEN-1] =
    '{11'd2, 11'd0, 11'd7, 11'd2047, 11'd1, 11'd33, 11'd1024, 11'd5};

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] sample;
    logic [6:0]  count;
    logic [9:0]  skip;
  } ring_request_t;

  typedef struct packed {
    logic [15:0] data;
    logic        valid;
    logic        last;
    logic [1:0]  status;
    logic [9:0]  fill;
  } ring_result_t;

  // Scoreboard: keeps its own copy of the buffer and the queue of results still owed.
  class ring_buffer_scoreboard;
    localparam int SLOT_MAX  = 1024;
    localparam int BURST_MAX = 64;

    logic [15:0]  samples [SLOT_MAX];
    int unsigned  head, tail, size_reg;
    ring_result_t owed_q[$];
    int mismatches, requests, results, emitted, overflows, errors, resizes;

    function new();
      head = 0;
      tail = 0;
      size_reg = SLOT_MAX;
      mismatches = 0;
      requests = 0;
      results = 0;
      emitted = 0;
      overflows = 0;
      errors = 0;
      resizes = 0;
    endfunction

    // Slots in use after clamping the size register.
    function int unsigned slots();
      if (size_reg < 2) return 2;
      if (size_reg > SLOT_MAX) return SLOT_MAX;
      return size_reg;
    endfunction

    function int unsigned fill();
      if (tail >= head) return tail - head;
      return slots() - head + tail;
    endfunction

    function int unsigned wrap_add(int unsigned idx, int unsigned n);
      int unsigned sum;
      sum = idx + n;
      if (sum >= slots()) sum -= slots();
      return sum;
    endfunction

    // Drop n samples from the head; dropping more than stored empties the buffer.
    function logic [1:0] discard(int unsigned n);
      if (n > fill()) begin
        head = tail;
        return srbo_pkg::ST_OVERFLOW;
      end
      head = wrap_add(head, n);
      return srbo_pkg::ST_OK;
    endfunction

    // A size write also empties the buffer.
    function void set_size(logic [10:0] value);
      size_reg = value;
      head = 0;
      tail = 0;
      resizes++;
    endfunction

    // Work out the results of one accepted request and queue them.
    function void note_request(ring_request_t rq);
      ring_result_t r;
      ring_result_t burst[$];
      logic [1:0]   st;
      int unsigned  pos;
      st = srbo_pkg::ST_OK;
      requests++;
      case (rq.kind)
        srbo_pkg::REQ_WRITE: begin
          samples[tail] = rq.sample;
          tail = wrap_add(tail, 1);
          if (tail == head) begin
            head = wrap_add(head, 1);
            st = srbo_pkg::ST_OVERFLOW;
          end
        end
        srbo_pkg::REQ_READ, srbo_pkg::REQ_PEEK: begin
          if (rq.count > BURST_MAX || rq.count > fill()) begin
            st = srbo_pkg::ST_ERROR;
          end else begin
            pos = head;
            for (int k = 0; k < int'(rq.count); k++) begin
              r = '0;
              r.data = samples[pos];
              r.valid = 1'b1;
              r.last = (k == int'(rq.count) - 1);
              burst.push_back(r);
              pos = wrap_add(pos, 1);
            end
            if (rq.kind == srbo_pkg::REQ_READ) head = pos;
            else st = discard(rq.skip);
          end
        end
        srbo_pkg::REQ_SKIP: st = discard(rq.skip);
        srbo_pkg::REQ_CLEAR: begin
          head = 0;
          tail = 0;
        end
        default: ;
      endcase
      // Requests that emit nothing still give one result.
      if (burst.size() == 0) begin
        r = '0;
        r.last = 1'b1;
        burst.push_back(r);
      end
      foreach (burst[i]) begin
        burst[i].status = st;
        burst[i].fill = 10'(fill());
        owed_q.push_back(burst[i]);
      end
      if (st == srbo_pkg::ST_OVERFLOW) overflows++;
      if (st == srbo_pkg::ST_ERROR) errors++;
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("%t mismatch: %s", $realtime, what);
    endfunction

    // Compare one accepted result with the oldest owed one.
    function void check_result(ring_result_t got);
      ring_result_t want;
      results++;
      if (got.valid) emitted++;
      if (owed_q.size() == 0) begin
        flag($sformatf("result with nothing owed: data %h valid %b last %b status %0d fill %0d",
                       got.data, got.valid, got.last, got.status, got.fill));
        return;
      end
      want = owed_q.pop_front();
      if (got.data !== want.data || got.valid !== want.valid || got.last !== want.last ||
          got.status !== want.status || got.fill !== want.fill) begin
        flag($sformatf({"expected data %h valid %b last %b status %0d fill %0d, ",
                        "got data %h valid %b last %b status %0d fill %0d"},
                       want.data, want.valid, want.last, want.status, want.fill,
                       got.data, got.valid, got.last, got.status, got.fill));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // [15:0] data_in, [22:16] count, [32:23] skip_count, zero pad
  logic [2:0]  s_tuser = '0;   // [2:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [15:0] data_out, [17:16] status, [27:18] stored_count, pad
  logic        m_tuser;        // [0] data_valid
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  ring_buffer_scoreboard sb;
  int send_idle_pct  = 10;
  int recv_stall_pct = 77;
  int cycles = 0;

  sample_ring_buffer_overwrite_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results still owed.",
               cycles, sb.owed_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each accepted result and stall at random.
  always @(posedge clk) begin : take_result
    ring_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.data = m_tdata[15:0];
        got.status = m_tdata[17:16];
        got.fill = m_tdata[27:18];
        got.valid = m_tuser;
        got.last = m_tlast;
        sb.check_result(got);
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one request, with a random gap first, and note it once accepted.
  task automatic send_request(input logic [2:0] kind, input logic [15:0] sample,
                              input logic [6:0] count, input logic [9:0] skip);
    ring_request_t rq;
    rq = '{kind: kind, sample: sample, count: count, skip: skip};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, skip, count, sample};
    s_tuser <= kind;
    do @(posedge clk); while (!s_tready);
    sb.note_request(rq);
  endtask

  // Hold off new requests until every owed result has come back.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.owed_q.size() != 0);
  endtask

  // Write the size register while the block is idle.
  task automatic write_size(input logic [10:0] value);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_size(value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [2:0]  kind;
    logic [15:0] sample;
    logic [6:0]  count;
    logic [9:0]  skip;
    int unsigned have, room;
    int          pick;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests at the reset size: empty buffer, extremes, errors, odd codes.
    send_request(srbo_pkg::REQ_READ, 16'h0000, 7'd1, 10'd0);
    send_request(srbo_pkg::REQ_PEEK, 16'h0000, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_WRITE, 16'h8000, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_WRITE, 16'h7FFF, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_WRITE, 16'hFFFF, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_WRITE, 16'h0000, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_PEEK, 16'h0000, 7'd2, 10'd1);
    send_request(srbo_pkg::REQ_READ, 16'h0000, 7'd4, 10'd0);
    send_request(srbo_pkg::REQ_READ, 16'h0000, 7'h7F, 10'd0);
    send_request(srbo_pkg::REQ_READ, 16'h0000, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_SKIP, 16'h0000, 7'd0, 10'h3FF);
    send_request(srbo_pkg::REQ_WRITE, 16'h1234, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_CLEAR, 16'h0000, 7'd0, 10'd0);
    for (int u = srbo_pkg::REQ_CLEAR + 1; u < 8; u++) begin
      send_request(3'(u), 16'hFFFF, 7'h7F, 10'h3FF);
    end

    // Small buffer: overwrite on full, peek with a skip past the end, wrapped read.
    wait_drain();
    write_size(11'd3);
    send_request(srbo_pkg::REQ_WRITE, 16'hA5A5, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_WRITE, 16'h5A5A, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_WRITE, 16'hC3C3, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_PEEK, 16'h0000, 7'd2, 10'd3);
    send_request(srbo_pkg::REQ_WRITE, 16'h0001, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_WRITE, 16'hFFFE, 7'd0, 10'd0);
    send_request(srbo_pkg::REQ_READ, 16'h0000, 7'd2, 10'd0);
    send_request(srbo_pkg::REQ_SKIP, 16'h0000, 7'd0, 10'd0);

    // Random requests, one batch per size setting, mostly well-formed.
    for (int phase = 0; phase < PLAN_LEN; phase++) begin
      wait_drain();
      write_size(SIZE_PLAN[phase]);
      if (phase < 3) begin
        send_idle_pct = 10;
        recv_stall_pct = 77;
      end else if (phase < 6) begin
        send_idle_pct = 77;
        recv_stall_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      for (int n = 0; n < RANDOM_BATCH; n++) begin
        // Halfway through each batch, let the output side run dry.
        if (n == RANDOM_BATCH / 2) wait_drain();
        have = sb.fill();
        room = (have < 64) ? have : 64;
        pick = $urandom_range(0, 99);
        kind = srbo_pkg::REQ_WRITE;
        sample = 16'($urandom);
        count = 7'($urandom);
        skip = 10'($urandom);
        if (pick < 45) begin
          kind = srbo_pkg::REQ_WRITE;
        end else if (pick < 65) begin
          kind = srbo_pkg::REQ_READ;
          count = 7'($urandom_range(0, room));
        end else if (pick < 77) begin
          kind = srbo_pkg::REQ_PEEK;
          count = 7'($urandom_range(0, room));
          if ($urandom_range(0, 4) != 0) skip = 10'($urandom_range(0, have - count));
        end else if (pick < 85) begin
          kind = srbo_pkg::REQ_SKIP;
          if ($urandom_range(0, 4) != 0) skip = 10'($urandom_range(0, have));
        end else if (pick < 88) begin
          kind = srbo_pkg::REQ_CLEAR;
        end else if (pick < 92) begin
          kind = 3'($urandom_range(srbo_pkg::REQ_CLEAR + 1, 7));
        end else begin
          // Noise: any code with fully random fields.
          kind = 3'($urandom_range(0, 7));
        end
        send_request(kind, sample, count, skip);
      end
    end

    wait_drain();
    repeat (TAIL_WAIT) @(posedge clk);
    $display("Sent %0d requests over %0d size settings; checked %0d results (%0d samples).",
             sb.requests, sb.resizes + 1, sb.results, sb.emitted);
    $display("Saw %0d overflow and %0d error statuses; %0d mismatches in all.",
             sb.overflows, sb.errors, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/srbo_pkg.sv
src/srbo_ram.sv
src/srbo_ctrl.sv
src/srbo_dp.sv
src/sample_ring_buffer_overwrite_top.sv
bench/sample_ring_buffer_overwrite_top_test.sv
